// ===== sv/mfb_pkg.sv =====
// Shared types, codes and defaults for the monochrome frame buffer draw engine.
`default_nettype none

package mfb_pkg;

   localparam int H_PIXELS_DEF      = 256;
   localparam int V_PIXELS_DEF      = 192;
   localparam int WORDS_PER_ROW_DEF = 16;
   localparam int SPRITE_DIM        = 8;
   localparam int CRD_W             = 12;

   typedef enum logic [2:0] {
      CMD_CLEAR  = 3'd0,
      CMD_SCROLL = 3'd1,
      CMD_PIXEL  = 3'd2,
      CMD_BOX    = 3'd3,
      CMD_RECT   = 3'd4,
      CMD_SPRITE = 3'd5,
      CMD_CLROWS = 3'd6,
      CMD_READ   = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_SET    = 2'd1,
      OP_TOGGLE = 2'd2,
      OP_NONE   = 2'd3
   } pix_op_type;

   typedef enum logic [3:0] {
      ST_INIT_FILL,
      ST_IDLE,
      ST_SETUP,
      ST_DISPATCH,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_FILL,
      ST_PLOT_RD,
      ST_PLOT_WR,
      ST_READ_RD,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic latch;
      logic setup;
      logic fill_wr;
      logic copy_rd;
      logic copy_wr;
      logic plot_rd;
      logic plot_wr;
      logic loop_step;
      logic read_rd;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      cmd_type kind;
      logic    copy_now;
      logic    fill_now;
      logic    copy_more;
      logic    fill_more;
      logic    loop_active;
      logic    loop_more;
      logic    hit;
      logic    slot_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== sv/mono_framebuffer_draw_engine.sv =====
// Top level of the 1-bit-per-pixel frame buffer draw engine.
//
//  channel | direction | ports               | content
//  --------+-----------+---------------------+---------------------------------
//  req     | in        | req_tvalid/tready   | one drawing command per transaction
//  rsp     | out       | rsp_tvalid/tready   | completion with read word
//
// Clear and large scroll write one buffer word per cycle (3072 words at defaults);
// scroll copies read each word and then write it, through the single read port.
// Pixel, box, rect and sprite read and write back each on-screen pixel and skip
// clipped-off ones without a memory access, between setup and completion.
// After reset a clearing pass over all V_PIXELS*WORDS_PER_ROW words runs, req_tready low.
// A pending result holds completion until rsp_tready; new commands wait for it.
`default_nettype none

module mono_framebuffer_draw_engine
   import mfb_pkg::*;
#(
   parameter int H_PIXELS      = H_PIXELS_DEF,
   parameter int V_PIXELS      = V_PIXELS_DEF,
   parameter int WORDS_PER_ROW = WORDS_PER_ROW_DEF
)
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // pos_x[9:0], pos_y[19:10], width_px[28:20], height_px[37:29], pixel_op[39:38],
   // row_count[48:40], sprite_bits[112:49], word_addr[124:113], zero fill[127:125]
   input  wire logic [127:0] req_tdata,
   // req_type[2:0]
   input  wire logic [2:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // read_data[15:0]
   output logic [15:0]       rsp_tdata,
   // done_type[2:0]
   output logic [2:0]        rsp_tuser
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   mfb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mfb_datapath #(
      .H_PIXELS      (H_PIXELS),
      .V_PIXELS      (V_PIXELS),
      .WORDS_PER_ROW (WORDS_PER_ROW)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .status     (status)
   );

   // engine is busy right after taking a command
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("command accepted while engine busy");

   // only a read word command carries data
   a_data_only_on_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != CMD_READ)) |-> (rsp_tdata == 16'd0))
      else $error("nonzero read data on non-read completion");

   // clearing pass blocks commands right after reset
   a_init_blocks: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !req_tready)
      else $error("command taken during reset clearing pass");

endmodule

`default_nettype wire

// ===== sv/mfb_ctrl.sv =====
// Command sequencer of the frame buffer draw engine.
`default_nettype none

module mfb_ctrl
   import mfb_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT_FILL;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT_FILL: begin
            if (!status.fill_more) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_SETUP;
         end
         ST_SETUP: state_in = ST_DISPATCH;
         ST_DISPATCH: begin
            if (status.kind == CMD_READ)   state_in = ST_READ_RD;
            else if (status.loop_active)   state_in = ST_PLOT_RD;
            else if (status.copy_now)      state_in = ST_COPY_RD;
            else if (status.fill_now)      state_in = ST_FILL;
            else                           state_in = ST_FINISH;
         end
         ST_COPY_RD: state_in = ST_COPY_WR;
         ST_COPY_WR: begin
            if (status.copy_more)      state_in = ST_COPY_RD;
            else if (status.fill_more) state_in = ST_FILL;
            else                       state_in = ST_FINISH;
         end
         ST_FILL: begin
            if (!status.fill_more) state_in = ST_FINISH;
         end
         ST_PLOT_RD: begin
            if (status.hit)             state_in = ST_PLOT_WR;
            else if (!status.loop_more) state_in = ST_FINISH;
         end
         ST_PLOT_WR: begin
            state_in = status.loop_more ? ST_PLOT_RD : ST_FINISH;
         end
         ST_READ_RD: state_in = ST_FINISH;
         ST_FINISH: begin
            if (status.slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_INIT_FILL: cmd.fill_wr = 1'b1;
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.latch  = req_tvalid;
         end
         ST_SETUP:   cmd.setup   = 1'b1;
         ST_COPY_RD: cmd.copy_rd = 1'b1;
         ST_COPY_WR: cmd.copy_wr = 1'b1;
         ST_FILL:    cmd.fill_wr = 1'b1;
         ST_PLOT_RD: begin
            // skip off-screen pixels without a memory access
            cmd.plot_rd   = status.hit;
            cmd.loop_step = !status.hit;
         end
         ST_PLOT_WR: begin
            cmd.plot_wr   = 1'b1;
            cmd.loop_step = 1'b1;
         end
         ST_READ_RD: cmd.read_rd  = 1'b1;
         ST_FINISH:  cmd.load_rsp = status.slot_free;
         default: ;
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/mfb_datapath.sv =====
// Frame buffer memory, loop counters, clipping and read-modify-write datapath.
`default_nettype none

module mfb_datapath
   import mfb_pkg::*;
#(
   parameter int H_PIXELS      = H_PIXELS_DEF,
   parameter int V_PIXELS      = V_PIXELS_DEF,
   parameter int WORDS_PER_ROW = WORDS_PER_ROW_DEF
)
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire ctrl_cmd_type  cmd,
   input  wire logic [127:0]  req_tdata,
   input  wire logic [2:0]    req_tuser,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [15:0]        rsp_tdata,
   output logic [2:0]         rsp_tuser,
   output dp_status_type      status
);

   localparam int FB = V_PIXELS * WORDS_PER_ROW;
   localparam int AW = $clog2(FB);
   localparam int CW = $clog2(FB + 1);

   typedef logic signed [CRD_W-1:0] crd_type;

   localparam crd_type HC  = crd_type'(H_PIXELS);
   localparam crd_type VC  = crd_type'(V_PIXELS);
   localparam crd_type SPC = crd_type'(SPRITE_DIM);

   // latched command
   cmd_type      kind_ff;
   logic [9:0]   x_ff, y_ff;
   logic [8:0]   w_ff, h_ff, cnt_ff;
   logic [1:0]   op_ff;
   logic [63:0]  bits_ff;
   logic [11:0]  waddr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= CMD_CLEAR;
      end else if (cmd.latch) begin
         kind_ff <= cmd_type'(req_tuser);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         x_ff     <= req_tdata[9:0];
         y_ff     <= req_tdata[19:10];
         w_ff     <= req_tdata[28:20];
         h_ff     <= req_tdata[37:29];
         op_ff    <= req_tdata[39:38];
         cnt_ff   <= req_tdata[48:40];
         bits_ff  <= req_tdata[112:49];
         waddr_ff <= req_tdata[124:113];
      end
   end

   crd_type xe, ye, we, he, xw, yh, r1_lo, r1_hi;
   logic    r1_ok;

   assign xe    = crd_type'(signed'(x_ff));
   assign ye    = crd_type'(signed'(y_ff));
   assign we    = crd_type'({1'b0, w_ff});
   assign he    = crd_type'({1'b0, h_ff});
   assign xw    = xe + we;
   assign yh    = ye + he;
   assign r1_lo = ye + crd_type'(1);
   assign r1_hi = yh - crd_type'(1);
   assign r1_ok = r1_lo < r1_hi;

   // pixel loop: outer o, inner i; rect walks a top/bottom edge phase and a side edge phase
   crd_type o_ff, o_end_ff, i_ff, i_start_ff, i_end_ff;
   crd_type o_in, o_end_in, i_in, i_start_in, i_end_in;
   logic    phase_ff, phase_in, active_ff, active_in, loop_more;
   crd_type x0, x1, y0, y1, sw, sh, i_inc, o_inc;

   assign x0    = (xe < 0) ? '0 : xe;
   assign x1    = (xw > HC) ? HC : xw;
   assign y0    = (ye < 0) ? '0 : ye;
   assign y1    = (yh > VC) ? VC : yh;
   assign sw    = (we > SPC) ? SPC : we;
   assign sh    = (he > SPC) ? SPC : he;
   assign i_inc = i_ff + crd_type'(1);
   assign o_inc = o_ff + crd_type'(1);
   assign loop_more = (i_inc < i_end_ff) || (o_inc < o_end_ff) ||
                      ((kind_ff == CMD_RECT) && !phase_ff && r1_ok);

   always_comb begin
      o_in       = o_ff;
      o_end_in   = o_end_ff;
      i_in       = i_ff;
      i_start_in = i_start_ff;
      i_end_in   = i_end_ff;
      phase_in   = phase_ff;
      active_in  = active_ff;
      if (cmd.setup) begin
         phase_in = 1'b0;
         case (kind_ff)
            CMD_PIXEL: begin
               o_in = '0; o_end_in = crd_type'(1);
               i_in = '0; i_start_in = '0; i_end_in = crd_type'(1);
               active_in = 1'b1;
            end
            CMD_BOX: begin
               o_in = y0; o_end_in = y1;
               i_in = x0; i_start_in = x0; i_end_in = x1;
               active_in = (y0 < y1) && (x0 < x1);
            end
            CMD_SPRITE: begin
               o_in = '0; o_end_in = sh;
               i_in = '0; i_start_in = '0; i_end_in = sw;
               active_in = (sh > 0) && (sw > 0);
            end
            CMD_RECT: begin
               o_in = '0; o_end_in = crd_type'(2);
               if (we > 0) begin
                  i_in = xe; i_start_in = xe; i_end_in = xw;
                  active_in = 1'b1;
               end else begin
                  phase_in = 1'b1;
                  i_in = r1_lo; i_start_in = r1_lo; i_end_in = r1_hi;
                  active_in = r1_ok;
               end
            end
            default: active_in = 1'b0;
         endcase
      end else if (cmd.loop_step) begin
         if (i_inc < i_end_ff) begin
            i_in = i_inc;
         end else if (o_inc < o_end_ff) begin
            o_in = o_inc;
            i_in = i_start_ff;
         end else if ((kind_ff == CMD_RECT) && !phase_ff && r1_ok) begin
            phase_in = 1'b1;
            o_in = '0;
            i_in = r1_lo; i_start_in = r1_lo; i_end_in = r1_hi;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         phase_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         phase_ff  <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      o_ff       <= o_in;
      o_end_ff   <= o_end_in;
      i_ff       <= i_in;
      i_start_ff <= i_start_in;
      i_end_ff   <= i_end_in;
   end

   // pixel under the loop
   crd_type    px, py;
   pix_op_type pop;
   logic       hit;
   logic [AW-1:0] paddr;
   logic [15:0]   pmask;

   always_comb begin
      px  = i_ff;
      py  = o_ff;
      pop = pix_op_type'(op_ff);
      case (kind_ff)
         CMD_PIXEL: begin
            px = xe;
            py = ye;
         end
         CMD_SPRITE: begin
            px  = xe + i_ff;
            py  = ye + o_ff;
            pop = bits_ff[{o_ff[2:0], ~i_ff[2:0]}] ? OP_SET : OP_CLEAR;
         end
         CMD_RECT: begin
            if (!phase_ff) begin
               px = i_ff;
               py = o_ff[0] ? r1_hi : ye;
            end else begin
               px = o_ff[0] ? (xw - crd_type'(1)) : xe;
               py = i_ff;
            end
         end
         default: ;
      endcase
   end

   assign hit   = (px >= 0) && (px < HC) && (py >= 0) && (py < VC) &&
                  (int'(px[9:4]) < WORDS_PER_ROW);
   assign paddr = AW'(int'(py[9:0]) * WORDS_PER_ROW + int'(px[9:4]));
   assign pmask = 16'h8000 >> px[3:0];

   // word sweep for clear, scroll and clear rows
   logic [CW-1:0] a_ff, a_in, ce_ff, ce_in, fe_ff, fe_in, sh_ff, sh_in, a_inc;
   logic [9:0]    ys, re, rc;

   assign a_inc = a_ff + CW'(1);
   assign ys    = y_ff[9] ? 10'd0 : y_ff;
   assign re    = ys + {1'b0, cnt_ff};
   assign rc    = (int'(re) > V_PIXELS) ? 10'(V_PIXELS) : re;

   always_comb begin
      a_in  = a_ff;
      ce_in = ce_ff;
      fe_in = fe_ff;
      sh_in = sh_ff;
      if (cmd.setup) begin
         a_in  = '0;
         ce_in = '0;
         fe_in = '0;
         case (kind_ff)
            CMD_CLEAR: fe_in = CW'(FB);
            CMD_SCROLL: begin
               fe_in = CW'(FB);
               sh_in = CW'(int'(cnt_ff) * WORDS_PER_ROW);
               if (int'(cnt_ff) < V_PIXELS) begin
                  ce_in = CW'(FB - int'(cnt_ff) * WORDS_PER_ROW);
               end
            end
            CMD_CLROWS: begin
               if (ys < rc) begin
                  a_in  = CW'(int'(ys) * WORDS_PER_ROW);
                  fe_in = CW'(int'(rc) * WORDS_PER_ROW);
               end
            end
            default: ;
         endcase
      end else if (cmd.fill_wr || cmd.copy_wr) begin
         a_in = a_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff  <= '0;
         ce_ff <= '0;
         fe_ff <= CW'(FB);
         sh_ff <= '0;
      end else begin
         a_ff  <= a_in;
         ce_ff <= ce_in;
         fe_ff <= fe_in;
         sh_ff <= sh_in;
      end
   end

   // frame buffer
   logic [15:0]   mem [FB];
   logic [15:0]   rd_q, wdata, pmod;
   logic [AW-1:0] raddr, waddr;
   logic          rd_en, wr_en, read_ok;

   assign rd_en   = cmd.copy_rd || cmd.plot_rd || cmd.read_rd;
   assign wr_en   = cmd.fill_wr || cmd.copy_wr || cmd.plot_wr;
   assign read_ok = int'(waddr_ff) < FB;

   always_comb begin
      raddr = paddr;
      if (cmd.copy_rd)      raddr = AW'(a_ff + sh_ff);
      else if (cmd.read_rd) raddr = AW'(waddr_ff);
   end

   always_comb begin
      case (pop)
         OP_CLEAR:  pmod = rd_q & ~pmask;
         OP_SET:    pmod = rd_q | pmask;
         OP_TOGGLE: pmod = rd_q ^ pmask;
         default:   pmod = rd_q;
      endcase
   end

   always_comb begin
      waddr = a_ff[AW-1:0];
      wdata = '0;
      if (cmd.copy_wr) begin
         wdata = rd_q;
      end else if (cmd.plot_wr) begin
         waddr = paddr;
         wdata = pmod;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[waddr] <= wdata;
      if (rd_en) rd_q <= mem[raddr];
   end

   // result register
   logic        rsp_valid_ff, slot_free;
   cmd_type     rsp_kind_ff;
   logic [15:0] rsp_data_ff;

   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_kind_ff <= kind_ff;
         rsp_data_ff <= ((kind_ff == CMD_READ) && read_ok) ? rd_q : 16'd0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign status.kind        = kind_ff;
   assign status.copy_now    = a_ff < ce_ff;
   assign status.fill_now    = a_ff < fe_ff;
   assign status.copy_more   = a_inc < ce_ff;
   assign status.fill_more   = a_inc < fe_ff;
   assign status.loop_active = active_ff;
   assign status.loop_more   = loop_more;
   assign status.hit         = hit;
   assign status.slot_free   = slot_free;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the 1-bit-per-pixel frame buffer draw engine.
`default_nettype none

module tb_top;
   import mfb_pkg::*;

   localparam int H_PX      = H_PIXELS_DEF;
   localparam int V_PX      = V_PIXELS_DEF;
   localparam int ROW_WORDS = WORDS_PER_ROW_DEF;
   localparam int FB_WORDS  = H_PX / 16 * 0 + ROW_WORDS * V_PX;
   localparam int IDLE_LIMIT = 400000;
   localparam int LONG_HOLD  = 400;

   typedef struct {
      cmd_type     kind;
      logic [9:0]  x;
      logic [9:0]  y;
      logic [8:0]  w;
      logic [8:0]  h;
      logic [1:0]  op;
      logic [8:0]  cnt;
      logic [63:0] bits;
      logic [11:0] addr;
   } draw_cmd_type;

   typedef struct {
      cmd_type     kind;
      logic [15:0] data;
   } done_rec_type;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic [2:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [15:0]  rsp_tdata;
   logic [2:0]   rsp_tuser;

   logic [15:0]  fb_img [0:FB_WORDS-1];
   done_rec_type done_q[$];
   int           err_cnt = 0;
   bit           idle_en = 1;
   bit           long_hold_req = 0;
   int           stall_left = 0;
   int           idle_cycles = 0;
   int           last_x = 0;
   int           last_y = 0;

   mono_framebuffer_draw_engine u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   // ---------------- frame buffer predictor ----------------
   function automatic void put_px(int x, int y, int op);
      int col;
      int idx;
      if (x < 0 || x >= H_PX || y < 0 || y >= V_PX) return;
      col = x >> 4;
      if (col >= ROW_WORDS) return;
      idx = y * ROW_WORDS + col;
      case (op)
         OP_CLEAR:  fb_img[idx][15 - (x & 15)] = 1'b0;
         OP_SET:    fb_img[idx][15 - (x & 15)] = 1'b1;
         OP_TOGGLE: fb_img[idx][15 - (x & 15)] = ~fb_img[idx][15 - (x & 15)];
         default: ;
      endcase
   endfunction

   function automatic logic [15:0] draw_predict(draw_cmd_type c);
      int x;
      int y;
      int w;
      int h;
      int n;
      int lim;
      int x0;
      int y0;
      int x1;
      int y1;
      logic [7:0] row;
      logic [15:0] data;
      x = $signed(c.x);
      y = $signed(c.y);
      w = c.w;
      h = c.h;
      n = c.cnt;
      data = '0;
      case (c.kind)
         CMD_CLEAR: foreach (fb_img[i]) fb_img[i] = '0;
         CMD_SCROLL: begin
            if (n >= V_PX) foreach (fb_img[i]) fb_img[i] = '0;
            else for (int i = 0; i < FB_WORDS; i++)
               fb_img[i] = (i + n * ROW_WORDS < FB_WORDS) ? fb_img[i + n * ROW_WORDS] : '0;
         end
         CMD_PIXEL: put_px(x, y, c.op);
         CMD_BOX: begin
            x0 = x < 0 ? 0 : x;
            y0 = y < 0 ? 0 : y;
            x1 = (x + w > H_PX) ? H_PX : x + w;
            y1 = (y + h > V_PX) ? V_PX : y + h;
            for (int r = y0; r < y1; r++)
               for (int k = x0; k < x1; k++) put_px(k, r, c.op);
         end
         CMD_RECT: begin
            for (int i = x; i < x + w; i++) begin
               put_px(i, y, c.op);
               put_px(i, y + h - 1, c.op);
            end
            for (int i = y + 1; i < y + h - 1; i++) begin
               put_px(x, i, c.op);
               put_px(x + w - 1, i, c.op);
            end
         end
         CMD_SPRITE: begin
            if (w > 8) w = 8;
            if (h > 8) h = 8;
            for (int r = 0; r < h; r++) begin
               row = c.bits[8*r +: 8];
               for (int k = 0; k < w; k++)
                  put_px(x + k, y + r, row[7 - k] ? OP_SET : OP_CLEAR);
            end
         end
         CMD_CLROWS: begin
            if (y < 0) y = 0;
            lim = (y + n) * ROW_WORDS;
            if (lim > FB_WORDS) lim = FB_WORDS;
            for (int i = y * ROW_WORDS; i < lim; i++) fb_img[i] = '0;
         end
         default: if (c.addr < FB_WORDS) data = fb_img[c.addr];
      endcase
      return data;
   endfunction

   // ---------------- stimulus helpers ----------------
   function automatic int gap_len();
      int r;
      if (!idle_en) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // Call from posedge context; returns at the handshake posedge, or after a random idle gap with req_tvalid low.
   task automatic send_cmd(draw_cmd_type c);
      done_rec_type d;
      bit rdy;
      int g;
      req_tvalid <= 1'b1;
      req_tuser  <= c.kind;
      req_tdata  <= {3'd0, c.addr, c.bits, c.cnt, c.op, c.h, c.w, c.y, c.x};
      do begin
         @(negedge clock);
         rdy = req_tready;
         @(posedge clock);
      end while (!rdy);
      d.kind = c.kind;
      d.data = draw_predict(c);
      done_q.push_back(d);
      g = gap_len();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   function automatic draw_cmd_type blank_cmd(cmd_type k);
      draw_cmd_type c;
      c.kind = k;
      c.x = 10'($urandom);
      c.y = 10'($urandom);
      c.w = 9'($urandom);
      c.h = 9'($urandom);
      c.op = 2'($urandom);
      c.cnt = 9'($urandom);
      c.bits = {$urandom, $urandom};
      c.addr = 12'($urandom);
      return c;
   endfunction

   task automatic shape(cmd_type k, int x, int y, int w, int h, int op);
      draw_cmd_type c;
      c = blank_cmd(k);
      c.x = 10'(x);
      c.y = 10'(y);
      c.w = 9'(w);
      c.h = 9'(h);
      c.op = 2'(op);
      send_cmd(c);
   endtask

   task automatic read_word(int addr);
      draw_cmd_type c;
      c = blank_cmd(CMD_READ);
      c.addr = 12'(addr);
      send_cmd(c);
   endtask

   task automatic row_cmd(cmd_type k, int y, int cnt);
      draw_cmd_type c;
      c = blank_cmd(k);
      c.y = 10'(y);
      c.cnt = 9'(cnt);
      send_cmd(c);
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (done_q.size() != 0) @(posedge clock);
   endtask

   // ---------------- tests ----------------
   task automatic test_pixels();
      shape(CMD_PIXEL, 0, 0, 0, 0, OP_SET);
      shape(CMD_PIXEL, 255, 191, 0, 0, OP_SET);
      shape(CMD_PIXEL, 17, 3, 0, 0, OP_TOGGLE);
      shape(CMD_PIXEL, 17, 3, 0, 0, OP_NONE);
      shape(CMD_PIXEL, 256, 0, 0, 0, OP_SET);
      shape(CMD_PIXEL, -512, 192, 0, 0, OP_SET);
      shape(CMD_PIXEL, 511, -1, 0, 0, OP_SET);
      read_word(0);
      read_word(3 * ROW_WORDS + 1);
      read_word(FB_WORDS - 1);
      shape(CMD_PIXEL, 0, 0, 0, 0, OP_CLEAR);
      read_word(0);
   endtask

   task automatic test_shapes();
      draw_cmd_type c;
      shape(CMD_BOX, -5, -3, 30, 12, OP_SET);
      shape(CMD_RECT, 4, 2, 1, 6, OP_TOGGLE);
      shape(CMD_RECT, 10, 5, 9, 1, OP_TOGGLE);
      shape(CMD_RECT, 250, 188, 20, 10, OP_SET);
      c = blank_cmd(CMD_SPRITE);
      c.x = 10'(14); c.y = 10'(1); c.w = 9'(511); c.h = 9'(300);
      send_cmd(c);
      c = blank_cmd(CMD_SPRITE);
      c.x = 10'(-3); c.y = 10'(188); c.w = 9'(8); c.h = 9'(8);
      send_cmd(c);
      for (int i = 0; i < 4; i++) read_word(i * ROW_WORDS + i % 2);
      read_word(188 * ROW_WORDS + 15);
      shape(CMD_BOX, 0, 0, 511, 511, OP_TOGGLE);
      read_word(1234);
      read_word(FB_WORDS);
      read_word(4095);
   endtask

   task automatic test_rows();
      row_cmd(CMD_SCROLL, 0, 0);
      row_cmd(CMD_SCROLL, 0, 5);
      read_word(5);
      row_cmd(CMD_CLROWS, -20, 30);
      row_cmd(CMD_CLROWS, 180, 511);
      row_cmd(CMD_CLROWS, 100, 0);
      read_word(100 * ROW_WORDS);
      row_cmd(CMD_SCROLL, 0, 192);
      shape(CMD_BOX, 0, 0, 40, 40, OP_SET);
      row_cmd(CMD_SCROLL, 0, 511);
      read_word(0);
      send_cmd(blank_cmd(CMD_CLEAR));
   endtask

   function automatic draw_cmd_type random_cmd();
      draw_cmd_type c;
      int r;
      int ax;
      int ay;
      r = $urandom_range(0, 99);
      if      (r < 40) c = blank_cmd(CMD_READ);
      else if (r < 55) c = blank_cmd(CMD_PIXEL);
      else if (r < 67) c = blank_cmd(CMD_BOX);
      else if (r < 77) c = blank_cmd(CMD_RECT);
      else if (r < 89) c = blank_cmd(CMD_SPRITE);
      else if (r < 93) c = blank_cmd(CMD_CLROWS);
      else if (r < 97) c = blank_cmd(CMD_SCROLL);
      else             c = blank_cmd(CMD_CLEAR);
      if ($urandom_range(0, 9) != 0) begin
         c.x = 10'(int'($urandom_range(0, H_PX + 30)) - 20);
         c.y = 10'(int'($urandom_range(0, V_PX + 30)) - 20);
      end
      if ($urandom_range(0, 39) != 0) begin
         c.w = 9'($urandom_range(0, 40));
         c.h = 9'($urandom_range(0, 40));
      end
      if ($urandom_range(0, 3) != 0) c.cnt = 9'($urandom_range(0, 24));
      if (c.kind != CMD_READ) begin
         last_x = $signed(c.x);
         last_y = $signed(c.y);
      end else if ($urandom_range(0, 4) != 0) begin
         ax = last_x + int'($urandom_range(0, 40));
         ay = last_y + int'($urandom_range(0, 40));
         ax = ax < 0 ? 0 : (ax >= H_PX ? H_PX - 1 : ax);
         ay = ay < 0 ? 0 : (ay >= V_PX ? V_PX - 1 : ay);
         c.addr = 12'(ay * ROW_WORDS + (ax >> 4));
      end
      return c;
   endfunction

   task automatic test_random(int n);
      for (int i = 0; i < n; i++) begin
         idle_en = ((i / 40) % 3) != 2;
         send_cmd(random_cmd());
      end
      idle_en = 1;
   endtask

   task automatic test_backpressure();
      wait_drain();
      long_hold_req = 1;
      idle_en = 0;
      for (int i = 0; i < 8; i++) begin
         if (i % 2) read_word($urandom_range(0, FB_WORDS - 1));
         else shape(CMD_PIXEL, $urandom_range(0, 40), $urandom_range(0, 8), 0, 0, OP_SET);
      end
      idle_en = 1;
      wait_drain();
      read_word(0);
   endtask

   // ---------------- result side ----------------
   always @(posedge clock) begin
      if (long_hold_req) begin
         long_hold_req <= 0;
         stall_left <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
         stall_left <= gap_len();
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(negedge clock) begin
      done_rec_type d;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (done_q.size() == 0) begin
            $error("result with no command outstanding: %h %h", rsp_tuser, rsp_tdata);
            err_cnt++;
         end else begin
            d = done_q.pop_front();
            if (rsp_tuser !== d.kind) begin
               $error("done_type expected %0d actual %0d", d.kind, rsp_tuser);
               err_cnt++;
            end
            if (rsp_tdata !== d.data) begin
               $error("read_data expected %h actual %h", d.data, rsp_tdata);
               err_cnt++;
            end
         end
      end
   end

   // Watchdog: count cycles without any transaction.
   always @(negedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      foreach (fb_img[i]) fb_img[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_pixels();
      test_shapes();
      test_rows();
      test_random(150);
      test_backpressure();
      wait_drain();
      repeat (50) @(posedge clock);
      if (err_cnt == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
